// ===== hw/rtl/bpfu_pkg.sv =====
package bpfu_pkg;

    localparam int MAX_BUFFERS = 64;

    localparam int PTR_W    = $clog2(MAX_BUFFERS);
    localparam int CNT_W    = $clog2(MAX_BUFFERS + 1);
    localparam int SUM_W    = PTR_W + 1;
    localparam int HANDLE_W = 6;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 7;

    typedef logic [PTR_W-1:0]    ptr_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [SUM_W-1:0]    sum_t;
    typedef logic [HANDLE_W-1:0] handle_t;
    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [CFG_W-1:0]    cfg_t;

    localparam cnt_t FULL_CNT    = cnt_t'(MAX_BUFFERS);
    localparam cfg_t CFG_RESET   = cfg_t'(64);

    localparam kind_t KIND_INIT     = 3'd0;
    localparam kind_t KIND_GET_FREE = 3'd1;
    localparam kind_t KIND_PUT_FREE = 3'd2;
    localparam kind_t KIND_GET_USED = 3'd3;
    localparam kind_t KIND_PUT_USED = 3'd4;
    localparam kind_t KIND_CLEAR    = 3'd5;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_EMPTY   = 2'd1;
    localparam status_t ST_FULL    = 2'd2;
    localparam status_t ST_ALREADY = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic fill_step;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath back to the controller
    typedef struct packed {
        logic init_go;
        logic fill_last;
        logic out_free;
    } dp_sts_t;

    // Wrap a position below twice the ring depth back into the ring
    function automatic ptr_t ring_pos(sum_t p);
        ptr_t r;
        if (p >= sum_t'(MAX_BUFFERS))
            r = ptr_t'(p - sum_t'(MAX_BUFFERS));
        else
            r = ptr_t'(p);
        return r;
    endfunction

endpackage

// ===== hw/rtl/bpfu_req_if.sv =====
interface bpfu_req_if;
    logic              valid;
    logic              ready;
    bpfu_pkg::kind_t   kind;
    bpfu_pkg::handle_t handle_in;
    logic              take_off;

    modport source (output valid, output kind, output handle_in, output take_off,
                    input ready);
    modport sink (input valid, input kind, input handle_in, input take_off,
                  output ready);
endinterface

// ===== hw/rtl/bpfu_rsp_if.sv =====
interface bpfu_rsp_if;
    logic              valid;
    logic              ready;
    bpfu_pkg::handle_t handle_out;
    logic              handle_valid;
    bpfu_pkg::status_t status;
    bpfu_pkg::cnt_t    used_count;
    bpfu_pkg::cnt_t    free_count;

    modport source (output valid, output handle_out, output handle_valid,
                    output status, output used_count, output free_count,
                    input ready);
    modport sink (input valid, input handle_out, input handle_valid,
                  input status, input used_count, input free_count,
                  output ready);
endinterface

// ===== hw/rtl/bpfu_cfg_if.sv =====
interface bpfu_cfg_if;
    logic           valid;
    logic           ready;
    bpfu_pkg::cfg_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bpfu_ram.sv =====
module bpfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/bpfu_ctrl.sv =====
module bpfu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bpfu_pkg::dp_sts_t   sts,
    output bpfu_pkg::ctrl_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = sts.init_go ? S_FILL : S_DONE;
            end
            S_FILL:
            begin
                if (sts.fill_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign cmd.accept    = in_ready && in_valid;
    assign cmd.exec      = (state_reg == S_EXEC);
    assign cmd.fill_step = (state_reg == S_FILL);
    assign cmd.load_out  = (state_reg == S_DONE) && sts.out_free;

endmodule

// ===== hw/rtl/bpfu_datapath.sv =====
module bpfu_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  bpfu_pkg::ctrl_cmd_t cmd,
    output bpfu_pkg::dp_sts_t   sts,
    input  bpfu_pkg::kind_t     req_kind,
    input  bpfu_pkg::handle_t   req_handle,
    input  logic                req_take_off,
    bpfu_cfg_if.sink            cfg,
    bpfu_rsp_if.source          rsp
);

    // Control state
    bpfu_pkg::cfg_t  count_reg;
    bpfu_pkg::ptr_t  free_head_reg, free_head_next;
    bpfu_pkg::cnt_t  free_fill_reg, free_fill_next;
    bpfu_pkg::ptr_t  used_head_reg, used_head_next;
    bpfu_pkg::cnt_t  used_fill_reg, used_fill_next;
    logic            pool_ready_reg, pool_ready_next;
    logic            out_valid_reg, out_valid_next;

    // Payload
    bpfu_pkg::kind_t   kind_reg;
    bpfu_pkg::handle_t handle_reg;
    logic              take_reg;
    bpfu_pkg::ptr_t    fill_idx_reg, fill_idx_next;
    bpfu_pkg::cnt_t    fill_n_reg, fill_n_next;
    bpfu_pkg::handle_t res_handle_reg, res_handle_next;
    logic              res_valid_reg, res_valid_next;
    bpfu_pkg::status_t res_status_reg, res_status_next;
    bpfu_pkg::handle_t out_handle_reg;
    logic              out_hvalid_reg;
    bpfu_pkg::status_t out_status_reg;
    bpfu_pkg::cnt_t    out_used_reg;
    bpfu_pkg::cnt_t    out_free_reg;

    // Ring ports
    logic              free_we, used_we;
    bpfu_pkg::ptr_t    free_waddr, used_waddr;
    bpfu_pkg::handle_t free_wdata, used_wdata;
    bpfu_pkg::handle_t free_rdata, used_rdata;
    bpfu_pkg::ptr_t    free_tail, used_tail;

    bpfu_ram #(
        .WIDTH (bpfu_pkg::HANDLE_W),
        .DEPTH (bpfu_pkg::MAX_BUFFERS)
    ) u_free_ring (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .raddr (free_head_reg),
        .rdata (free_rdata)
    );

    bpfu_ram #(
        .WIDTH (bpfu_pkg::HANDLE_W),
        .DEPTH (bpfu_pkg::MAX_BUFFERS)
    ) u_used_ring (
        .clk   (clk),
        .we    (used_we),
        .waddr (used_waddr),
        .wdata (used_wdata),
        .raddr (used_head_reg),
        .rdata (used_rdata)
    );

    assign free_tail = bpfu_pkg::ring_pos(bpfu_pkg::sum_t'(free_head_reg)
                                          + bpfu_pkg::sum_t'(free_fill_reg));
    assign used_tail = bpfu_pkg::ring_pos(bpfu_pkg::sum_t'(used_head_reg)
                                          + bpfu_pkg::sum_t'(used_fill_reg));

    assign sts.init_go   = (kind_reg == bpfu_pkg::KIND_INIT) && !pool_ready_reg
                           && (count_reg != '0);
    assign sts.fill_last = (bpfu_pkg::cnt_t'(fill_idx_reg)
                            == fill_n_reg - bpfu_pkg::cnt_t'(1));
    assign sts.out_free  = !out_valid_reg || rsp.ready;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        free_head_next  = free_head_reg;
        free_fill_next  = free_fill_reg;
        used_head_next  = used_head_reg;
        used_fill_next  = used_fill_reg;
        pool_ready_next = pool_ready_reg;
        fill_idx_next   = fill_idx_reg;
        fill_n_next     = fill_n_reg;
        res_handle_next = res_handle_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        free_we         = 1'b0;
        free_waddr      = free_tail;
        free_wdata      = handle_reg;
        used_we         = 1'b0;
        used_waddr      = used_tail;
        used_wdata      = handle_reg;

        if (cmd.exec)
        begin
            res_handle_next = '0;
            res_valid_next  = 1'b0;
            res_status_next = bpfu_pkg::ST_OK;
            unique case (kind_reg)
                bpfu_pkg::KIND_INIT:
                begin
                    if (pool_ready_reg)
                    begin
                        res_status_next = bpfu_pkg::ST_ALREADY;
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_next = bpfu_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        fill_idx_next = '0;
                        fill_n_next   = (bpfu_pkg::cnt_t'(count_reg) > bpfu_pkg::FULL_CNT)
                                        ? bpfu_pkg::FULL_CNT
                                        : bpfu_pkg::cnt_t'(count_reg);
                    end
                end
                bpfu_pkg::KIND_GET_FREE:
                begin
                    if (free_fill_reg != '0)
                    begin
                        res_handle_next = free_rdata;
                        res_valid_next  = 1'b1;
                        free_head_next  = bpfu_pkg::ring_pos(
                            bpfu_pkg::sum_t'(free_head_reg) + bpfu_pkg::sum_t'(1));
                        free_fill_next  = free_fill_reg - bpfu_pkg::cnt_t'(1);
                    end
                    else
                    begin
                        res_status_next = bpfu_pkg::ST_EMPTY;
                    end
                end
                bpfu_pkg::KIND_PUT_FREE:
                begin
                    if (free_fill_reg != bpfu_pkg::FULL_CNT)
                    begin
                        free_we        = 1'b1;
                        free_fill_next = free_fill_reg + bpfu_pkg::cnt_t'(1);
                    end
                    else
                    begin
                        res_status_next = bpfu_pkg::ST_FULL;
                    end
                end
                bpfu_pkg::KIND_GET_USED:
                begin
                    if (used_fill_reg != '0)
                    begin
                        res_handle_next = used_rdata;
                        res_valid_next  = 1'b1;
                        if (take_reg)
                        begin
                            used_head_next = bpfu_pkg::ring_pos(
                                bpfu_pkg::sum_t'(used_head_reg) + bpfu_pkg::sum_t'(1));
                            used_fill_next = used_fill_reg - bpfu_pkg::cnt_t'(1);
                        end
                    end
                    else
                    begin
                        res_status_next = bpfu_pkg::ST_EMPTY;
                    end
                end
                bpfu_pkg::KIND_PUT_USED:
                begin
                    if (used_fill_reg != bpfu_pkg::FULL_CNT)
                    begin
                        used_we        = 1'b1;
                        used_fill_next = used_fill_reg + bpfu_pkg::cnt_t'(1);
                    end
                    else
                    begin
                        res_status_next = bpfu_pkg::ST_FULL;
                    end
                end
                bpfu_pkg::KIND_CLEAR:
                begin
                    free_head_next  = '0;
                    free_fill_next  = '0;
                    used_head_next  = '0;
                    used_fill_next  = '0;
                    pool_ready_next = 1'b0;
                end
                default:
                begin
                    // unused kinds leave everything as is
                end
            endcase
        end

        if (cmd.fill_step)
        begin
            // append one handle per cycle, drop it when the ring is full
            free_wdata = bpfu_pkg::handle_t'(fill_idx_reg);
            if (free_fill_reg != bpfu_pkg::FULL_CNT)
            begin
                free_we        = 1'b1;
                free_fill_next = free_fill_reg + bpfu_pkg::cnt_t'(1);
            end
            else
            begin
                res_status_next = bpfu_pkg::ST_FULL;
            end
            fill_idx_next = fill_idx_reg + bpfu_pkg::ptr_t'(1);
            if (sts.fill_last)
                pool_ready_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= bpfu_pkg::CFG_RESET;
            free_head_reg  <= '0;
            free_fill_reg  <= '0;
            used_head_reg  <= '0;
            used_fill_reg  <= '0;
            pool_ready_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                count_reg <= cfg.data;
            free_head_reg  <= free_head_next;
            free_fill_reg  <= free_fill_next;
            used_head_reg  <= used_head_next;
            used_fill_reg  <= used_fill_next;
            pool_ready_reg <= pool_ready_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg   <= req_kind;
            handle_reg <= req_handle;
            take_reg   <= req_take_off;
        end
        fill_idx_reg   <= fill_idx_next;
        fill_n_reg     <= fill_n_next;
        res_handle_reg <= res_handle_next;
        res_valid_reg  <= res_valid_next;
        res_status_reg <= res_status_next;
        if (cmd.load_out)
        begin
            out_handle_reg <= res_handle_reg;
            out_hvalid_reg <= res_valid_reg;
            out_status_reg <= res_status_reg;
            out_used_reg   <= used_fill_reg;
            out_free_reg   <= free_fill_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.handle_out   = out_handle_reg;
    assign rsp.handle_valid = out_hvalid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.used_count   = out_used_reg;
    assign rsp.free_count   = out_free_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_fill_reg <= bpfu_pkg::FULL_CNT && used_fill_reg <= bpfu_pkg::FULL_CNT)
        else $error("queue fill beyond ring depth");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && kind_reg == bpfu_pkg::KIND_CLEAR
        |=> free_fill_reg == '0 && used_fill_reg == '0 && !pool_ready_reg)
        else $error("clear left queue state behind");

    a_get_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && kind_reg == bpfu_pkg::KIND_GET_FREE && free_fill_reg != '0
        |=> free_fill_reg == $past(free_fill_reg) - bpfu_pkg::cnt_t'(1))
        else $error("get free did not pop one entry");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("result beat lost on load");

    a_handle_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_hvalid_reg |-> out_status_reg == bpfu_pkg::ST_OK)
        else $error("returned handle with error status");

endmodule

// ===== hw/rtl/buffer_pool_free_used_queues.sv =====
// Buffer handle pool with a free queue and a used queue.
//
// req carries one operation per beat: kind (init, get free, put free,
// get used, put used, clear), handle_in for the puts and take_off for get
// used. rsp returns exactly one beat per request with the handle, its valid
// flag, a status code and both queue counts after the operation. cfg writes
// buffer_count, how many handles init appends (at most the ring depth);
// write it only while no request is in flight.
//
// A request goes through accept, execute and the load of the output register
// before its result beat. Init adds a fill step per handle, up to the ring
// depth, since the free ring's single write port takes one handle a cycle.
// Each ring is a RAM with a registered read that is always aimed at the
// queue head, so a get finds its data in the execute cycle. A new request
// is taken only once the previous result is in the output register.
//
// Reset empties both queues, clears the set-up mark and sets buffer_count
// to 64; ring contents are not cleared. When rsp stalls, the pending beat
// holds in the output register and one more finished result waits inside;
// req is taken again once that result moves to the output register.
module buffer_pool_free_used_queues (
    input logic         clk,
    input logic         rst_n,
    bpfu_req_if.sink    req,
    bpfu_rsp_if.source  rsp,
    bpfu_cfg_if.sink    cfg
);

    bpfu_pkg::ctrl_cmd_t cmd;
    bpfu_pkg::dp_sts_t   sts;
    logic                in_ready;

    assign req.ready = in_ready;

    bpfu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bpfu_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_kind     (req.kind),
        .req_handle   (req.handle_in),
        .req_take_off (req.take_off),
        .cfg          (cfg),
        .rsp          (rsp)
    );

endmodule
